/* rtl/lwe_pkg.sv */
// ----------------------------------------------------------------------------
// lwe_pkg
// Shared types and constants for the logarithm with error propagation block.
// ----------------------------------------------------------------------------
package lwe_pkg;

    // register byte addresses
    localparam logic [2:0] ADDR_FILLER = 3'd0;
    localparam logic [2:0] ADDR_MODE   = 3'd4;

    // log2 fraction bits produced by the squaring cells
    localparam int LOG2_FRAC = 24;
    // number of cells in the chain (one quotient bit each)
    localparam int NUM_CELLS = 32;

    // ln 2 and log10 2 in Q.30
    localparam logic signed [31:0] K_LN2     = 32'sd744261118;
    localparam logic signed [31:0] K_LOG10_2 = 32'sd323228497;
    // 0.434 in Q0.32
    localparam logic [31:0] C_BASE10 = 32'd1864015806;

    // data carried from cell to cell
    typedef struct packed {
        logic        bad;      // sample zero or negative
        logic        natural;
        logic [31:0] filler;
        logic [4:0]  lead;     // leading one position
        logic [30:0] mant;     // mantissa Q1.30
        logic [23:0] frac;     // log2 fraction bits so far
        logic [30:0] divisor;
        logic [30:0] rem;
        logic [31:0] num_lo;   // numerator bits still to shift in
        logic [31:0] quo;
        logic        sat;
    } lwe_pipe_t;

endpackage

/* rtl/lwe_cell.sv */
// ----------------------------------------------------------------------------
// lwe_cell
// One chain cell: a mantissa squaring step (when SQ_EN) and one restoring division step.
// ----------------------------------------------------------------------------
module lwe_cell
    import lwe_pkg::*;
#(
    parameter bit SQ_EN = 1'b1
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_vld,
    input  lwe_pipe_t in_data,
    output logic      out_vld,
    output lwe_pipe_t out_data
);

    logic        vld_reg;
    lwe_pipe_t   data_reg;
    lwe_pipe_t   data_next;
    logic [61:0] sq;
    logic [31:0] sq_top;
    logic [31:0] r2;

    // squaring and division step
    always_comb
    begin
        data_next = in_data;
        sq        = in_data.mant * in_data.mant;
        sq_top    = sq[61:30];
        if (SQ_EN)
        begin
            if (sq_top[31])
            begin
                data_next.mant = sq_top[31:1];
                data_next.frac = {in_data.frac[22:0], 1'b1};
            end
            else
            begin
                data_next.mant = sq_top[30:0];
                data_next.frac = {in_data.frac[22:0], 1'b0};
            end
        end
        r2 = {in_data.rem, in_data.num_lo[31]};
        data_next.num_lo = {in_data.num_lo[30:0], 1'b0};
        if (r2 >= {1'b0, in_data.divisor})
        begin
            data_next.rem = 31'(r2 - {1'b0, in_data.divisor});
            data_next.quo = {in_data.quo[30:0], 1'b1};
        end
        else
        begin
            data_next.rem = r2[30:0];
            data_next.quo = {in_data.quo[30:0], 1'b0};
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

/* rtl/log_with_error_propagation_top.sv */
// ----------------------------------------------------------------------------
// log_with_error_propagation_top
// Logarithm of a fixed-point sample with first-order error propagation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: sample_value (signed) and sample_error (unsigned), both
//   with FRAC_BITS fraction bits, under in_valid/in_ready.
//   Output channel: log_value, log_error and error_saturated under
//   out_valid/out_ready. One result for every request, in order.
//   Configuration over the APB port: filler at 0x0, natural_mode at 0x4.
//   Write only while no request is in flight.
// Pipeline: input register, one preparation stage, 32 chain cells, three
//   rounding stages.
// Throughput: one request per cycle unless a result stalls; the chain of
//   32 cells (one quotient bit each, squaring in the first 24) is fully pipelined.
// Reset: all stage valids clear, filler = 0, natural_mode = 1.
// Stall: when out_ready is low with a result waiting, the whole pipeline
//   holds and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module log_with_error_propagation_top
    import lwe_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample_value,
    input  logic [31:0]        sample_error,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] log_value,
    output logic [31:0]        log_error,
    output logic               error_saturated
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int SH = LOG2_FRAC + 30 - FRAC_BITS;

    logic [31:0] filler_reg;
    logic        natural_reg;
    logic        adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filler_reg  <= 32'd0;
            natural_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == ADDR_MODE[2])
                natural_reg <= pwdata[0];
            else
                filler_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_FILLER[2]) ? filler_reg : {31'd0, natural_reg};

    // whole pipeline advances unless a result is stalled
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // stage 1: input register
    logic        s1_vld_reg;
    logic [31:0] s1_y_reg;
    logic [31:0] s1_e_reg;
    logic        s1_nat_reg;
    logic [31:0] s1_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_y_reg    <= sample_value;
            s1_e_reg    <= sample_error;
            s1_nat_reg  <= natural_reg;
            s1_fill_reg <= filler_reg;
        end
    end

    // stage 2: leading one, mantissa and error numerator
    logic [4:0]  lead;
    logic [61:0] mshift;
    logic [63:0] e_prod;
    logic [63:0] num64;

    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (s1_y_reg[i])
                lead = 5'(i);
        end
        mshift = {31'd0, s1_y_reg[30:0]} << (5'd30 - lead);
        e_prod = 64'(s1_e_reg) * 64'(C_BASE10);
        if (s1_nat_reg)
            num64 = 64'(s1_e_reg) << FRAC_BITS;
        else
            num64 = e_prod >> (32 - FRAC_BITS);
    end

    logic          s2_vld_reg;
    logic          s2_bad_reg;
    logic          s2_nat_reg;
    logic [31:0]   s2_fill_reg;
    logic [4:0]    s2_lead_reg;
    logic [30:0]   s2_mant_reg;
    logic [30:0]   s2_y_reg;
    logic [NW-1:0] s2_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_bad_reg  <= (s1_y_reg == 32'd0) || s1_y_reg[31];
            s2_nat_reg  <= s1_nat_reg;
            s2_fill_reg <= s1_fill_reg;
            s2_lead_reg <= lead;
            s2_mant_reg <= mshift[30:0];
            s2_y_reg    <= s1_y_reg[30:0];
            s2_num_reg  <= num64[NW-1:0];
        end
    end

    // chain head: saturation check and divider set-up
    lwe_pipe_t head;

    always_comb
    begin
        head.bad     = s2_bad_reg;
        head.natural = s2_nat_reg;
        head.filler  = s2_fill_reg;
        head.lead    = s2_lead_reg;
        head.mant    = s2_mant_reg;
        head.frac    = '0;
        head.divisor = s2_y_reg;
        head.rem     = 31'(s2_num_reg[NW-1:32]);
        head.num_lo  = s2_num_reg[31:0];
        head.quo     = '0;
        head.sat     = 31'(s2_num_reg[NW-1:32]) >= s2_y_reg;
    end

    // chain of cells
    logic      c_vld  [NUM_CELLS+1];
    lwe_pipe_t c_data [NUM_CELLS+1];

    assign c_vld[0]  = s2_vld_reg;
    assign c_data[0] = head;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        lwe_cell #(
            .SQ_EN (g < LOG2_FRAC)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_vld   (c_vld[g]),
            .in_data  (c_data[g]),
            .out_vld  (c_vld[g+1]),
            .out_data (c_data[g+1])
        );
    end

    // stage p1: log2 times scale constant
    lwe_pipe_t         tail;
    logic signed [31:0] l2;
    logic signed [31:0] kk;
    logic signed [63:0] prod;

    assign tail = c_data[NUM_CELLS];

    always_comb
    begin
        l2   = (($signed({27'd0, tail.lead}) - 32'(FRAC_BITS)) <<< LOG2_FRAC)
               + $signed({8'd0, tail.frac});
        kk   = tail.natural ? K_LN2 : K_LOG10_2;
        prod = l2 * kk;
    end

    logic               p1_vld_reg;
    logic signed [63:0] p1_prod_reg;
    logic               p1_bad_reg;
    logic [31:0]        p1_fill_reg;
    logic [31:0]        p1_quo_reg;
    logic               p1_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else if (adv)
            p1_vld_reg <= c_vld[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_prod_reg <= prod;
            p1_bad_reg  <= tail.bad;
            p1_fill_reg <= tail.filler;
            p1_quo_reg  <= tail.quo;
            p1_sat_reg  <= tail.sat;
        end
    end

    // stage p2: magnitude of product
    logic        p2_vld_reg;
    logic [63:0] p2_mag_reg;
    logic        p2_neg_reg;
    logic        p2_bad_reg;
    logic [31:0] p2_fill_reg;
    logic [31:0] p2_quo_reg;
    logic        p2_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_vld_reg <= 1'b0;
        else if (adv)
            p2_vld_reg <= p1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_neg_reg  <= p1_prod_reg[63];
            p2_mag_reg  <= p1_prod_reg[63] ? (64'd0 - 64'(p1_prod_reg))
                                           : 64'(p1_prod_reg);
            p2_bad_reg  <= p1_bad_reg;
            p2_fill_reg <= p1_fill_reg;
            p2_quo_reg  <= p1_quo_reg;
            p2_sat_reg  <= p1_sat_reg;
        end
    end

    // output stage: rounding, sign and special cases
    logic [63:0] rnd;
    logic [63:0] rsh;
    logic [63:0] sval;

    always_comb
    begin
        rnd  = p2_mag_reg + (64'd1 << (SH - 1));
        rsh  = rnd >> SH;
        sval = p2_neg_reg ? (64'd0 - rsh) : rsh;
    end

    logic        out_vld_reg;
    logic [31:0] out_val_reg;
    logic [31:0] out_err_reg;
    logic        out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= p2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (p2_bad_reg)
            begin
                out_val_reg <= p2_fill_reg;
                out_err_reg <= 32'd0;
                out_sat_reg <= 1'b0;
            end
            else
            begin
                out_val_reg <= sval[31:0];
                out_err_reg <= p2_sat_reg ? 32'hFFFF_FFFF : p2_quo_reg;
                out_sat_reg <= p2_sat_reg;
            end
        end
    end

    assign out_valid       = out_vld_reg;
    assign log_value       = $signed(out_val_reg);
    assign log_error       = out_err_reg;
    assign error_saturated = out_sat_reg;

endmodule

/* tb/sv/tb_log_with_error_propagation_top.sv */
// ----------------------------------------------------------------------------
// tb_log_with_error_propagation_top
// Self-checking bench: directed table then random requests, each result
// compared with an in-bench predictor of log value and propagated error.
// ----------------------------------------------------------------------------
module tb_log_with_error_propagation_top;
    import lwe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int LATENCY = 38;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] value;
        logic [31:0]        err;
        logic               sat;
    } log_result_t;

    typedef struct {
        logic signed [31:0] sample;
        logic [31:0]        err;
        logic               known;   // expected result typed in
        log_result_t        res;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] sample_value = '0;
    logic [31:0]        sample_error = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] log_value;
    logic [31:0]        log_error;
    logic               error_saturated;

    // predictor copy of the registers
    logic [31:0] cfg_filler = '0;
    logic        cfg_natural = 1'b1;

    log_result_t pending_logs[$];
    int          error_count = 0;
    longint      cycle_count = 0;

    log_with_error_propagation_top #(.FRAC_BITS(FRAC)) u_top (.*);

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // log2 in q.24 by repeated squaring of the mantissa
    function automatic longint log2_q24(input logic [31:0] y);
        int p;
        logic [63:0] m;
        longint frac;
        p = 0;
        for (int b = 0; b < 32; b++)
            if (y[b]) p = b;
        m = 64'(y) << (30 - p);
        frac = 0;
        for (int i = 0; i < 24; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(p - FRAC) * (longint'(1) << 24) + frac;
    endfunction

    function automatic log_result_t predict_log(input logic [31:0] y, input logic [31:0] e);
        log_result_t r;
        longint prod;
        logic [63:0] mag, rnd;
        logic [127:0] num, q;
        logic [63:0] den;
        if (y == 0 || y[31])
        begin
            r.value = cfg_filler;
            r.err = '0;
            r.sat = 1'b0;
            return r;
        end
        prod = log2_q24(y) * (cfg_natural ? longint'(K_LN2) : longint'(K_LOG10_2));
        mag = (prod < 0) ? 64'(-prod) : 64'(prod);
        rnd = (mag + (64'd1 << 37)) >> 38;
        r.value = (prod < 0) ? 32'(-rnd) : 32'(rnd);
        num = 128'(e) * (cfg_natural ? 128'h1_0000_0000 : 128'(C_BASE10));
        den = 64'(y) << (32 - FRAC);
        q = num / den;
        if (q > 128'hFFFF_FFFF)
        begin
            r.err = 32'hFFFF_FFFF;
            r.sat = 1'b1;
        end
        else
        begin
            r.err = q[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_FILLER) cfg_filler = data;
        else if (addr == ADDR_MODE) cfg_natural = data[0];
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_logs.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // send one request, holding valid until accepted; valid stays high
    // after acceptance so that a request with no gap follows directly
    task automatic send_sample(input logic [31:0] y, input logic [31:0] e,
                               input bit known, input log_result_t kres);
        int gap;
        log_result_t p;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        p = predict_log(y, e);
        if (known && (p.value !== kres.value || p.err !== kres.err || p.sat !== kres.sat))
            report_mismatch($sformatf("typed expectation differs for sample %h", y));
        pending_logs.push_back(known ? kres : p);
        in_valid <= 1'b1; sample_value <= y; sample_error <= e;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic log_result_t mk(input logic [31:0] v, input logic [31:0] e, input logic s);
        log_result_t r;
        r.value = v; r.err = e; r.sat = s;
        return r;
    endfunction

    // result check and receiver stalls
    int stall_left = 0;
    always @(posedge clk)
    begin
        log_result_t x;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_logs.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    x = pending_logs.pop_front();
                    if (log_value !== x.value)
                        report_mismatch($sformatf("log_value %h exp %h", log_value, x.value));
                    if (log_error !== x.err)
                        report_mismatch($sformatf("log_error %h exp %h", log_error, x.err));
                    if (error_saturated !== x.sat)
                        report_mismatch($sformatf("error_saturated %b exp %b",
                                                  error_saturated, x.sat));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_ready && out_valid)
            begin
                if (cycle_count % 2000 < 600) stall_left <= 0;
                else stall_left <= $urandom_range(0, 11);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t rows[$];
        logic [31:0] y, e;
        int r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, natural mode after reset
        rows = '{
            '{32'h0000_0000, 32'h0000_1234, 1'b1, mk(32'h0, 32'h0, 1'b0)},
            '{32'h8000_0000, 32'hFFFF_FFFF, 1'b1, mk(32'h0, 32'h0, 1'b0)},
            '{32'hFFFF_FFFF, 32'h0001_0000, 1'b1, mk(32'h0, 32'h0, 1'b0)},
            '{32'h0001_0000, 32'h0000_0000, 1'b1, mk(32'h0, 32'h0, 1'b0)},
            '{32'h0001_0000, 32'h0001_0000, 1'b1, mk(32'h0, 32'h0001_0000, 1'b0)},
            '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, mk(32'hFFF4_E8DF, 32'hFFFF_FFFF, 1'b1)},
            '{32'h0000_0001, 32'h0000_0001, 1'b0, mk(0, 0, 0)},
            '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, mk(0, 0, 0)},
            '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, mk(0, 0, 0)},
            '{32'h0002_B7E1, 32'h0000_8000, 1'b0, mk(0, 0, 0)},
            '{32'h0000_8000, 32'h0000_FFFF, 1'b0, mk(0, 0, 0)},
            '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, mk(0, 0, 0)}
        };
        foreach (rows[i])
            send_sample(rows[i].sample, rows[i].err, rows[i].known, rows[i].res);
        drain_and_settle();

        // every register, extremes included, then random phases
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: write_reg(ADDR_FILLER, 32'h8000_0000);
                1: write_reg(ADDR_FILLER, 32'h7FFF_FFFF);
                default: write_reg(ADDR_FILLER, $urandom);
            endcase
            write_reg(ADDR_MODE, (phase % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF);
            if (phase == 0)
            begin
                send_sample(32'h0000_0000, 32'h1, 1'b1, mk(32'h8000_0000, 32'h0, 1'b0));
                send_sample(32'h0001_0000, 32'h0, 1'b1, mk(32'h0, 32'h0, 1'b0));
            end
            for (int n = 0; n < 250; n++)
            begin
                r = $urandom_range(0, 9);
                y = $urandom;
                if (r < 4) y = y >> $urandom_range(0, 31);
                else if (r < 5) y = {1'b1, y[30:0]};
                else if (r < 6) y = (r == 5 && y[0]) ? 32'h0 : 32'h0000_0001 << $urandom_range(0, 30);
                e = $urandom;
                if ($urandom_range(0, 3) == 0) e = e >> $urandom_range(0, 31);
                send_sample(y, e, 1'b0, mk(0, 0, 0));
                // pause until everything is back
                if (n == 100)
                begin
                    in_valid <= 1'b0;
                    while (pending_logs.size() != 0) @(posedge clk);
                end
            end
            drain_and_settle();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
